// ----- hw/rtl/sorted_linked_list_engine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted linked list engine: assertion macros
// Shared property wrappers for the engine's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LINKED_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SLL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sll_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted linked list engine: package
// Sizes, command and status codes, controller states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sll_pkg;

   localparam int CAPACITY  = 16;
   localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IDX_W     = $clog2(CAPACITY + 1);
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 5;
   localparam int CNT_EXT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

   localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(CAPACITY);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_NEXT   = 2'd2,
      CMD_REMOVE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_END   = 2'd1,
      STS_FULL  = 2'd2,
      STS_NOCUR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CUR_NONE = 2'd0,
      CUR_ON   = 2'd1,
      CUR_BACK = 2'd2
   } cur_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_ALLOC,
      ST_WALK,
      ST_LINK,
      ST_LINK2,
      ST_RD_FIRST,
      ST_NXT_LINK,
      ST_NXT_VAL,
      ST_RM_RD,
      ST_RM_FIX,
      ST_FINISH
   } state_type;

   // entry count as reported on the result word
   function automatic logic [COUNT_W-1:0] count_out(input logic [IDX_W-1:0] c);
      logic [CNT_EXT_W-1:0] ext;
      ext = CNT_EXT_W'(c);
      return ext[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sll_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted linked list engine: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_linked_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted linked list engine
// Linked list of signed words in a node RAM with a free chain; commands
// insert (front or sorted), first, next and remove under the cursor.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready  command, value
//  rsp      out  rsp_valid/rsp_ready  status, read_value, entry_count
//  csr      in   csr_valid/csr_ready  sorted_mode
//
//  One command at a time, accept to next accept. A sorted insert walks the
//  list, one node RAM read per step. The result register frees the
//  controller: a new command is taken while the previous result waits.
//  Synchronous reset; the link RAM needs no clearing pass (per-entry valid
//  bits give the initial free chain).
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_linked_list_engine_unit_defines.svh"

module sorted_linked_list_engine_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_command,
   input  wire logic signed [sll_pkg::VALUE_W-1:0] req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic signed [sll_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic [sll_pkg::COUNT_W-1:0]             rsp_entry_count,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic                               csr_sorted_mode
);

   sll_pkg::state_type     state_ff, state_in;
   sll_pkg::cur_state_type cstate_ff, cstate_in;
   sll_pkg::status_type    res_status_ff, res_status_in;

   logic                               sorted_ff;
   logic signed [sll_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [sll_pkg::IDX_W-1:0]          node_ff, node_in;
   logic [sll_pkg::IDX_W-1:0]          cur_ff, cur_in;
   logic [sll_pkg::IDX_W-1:0]          pred_ff, pred_in;
   logic [sll_pkg::IDX_W-1:0]          nx_ff, nx_in;
   logic [sll_pkg::IDX_W-1:0]          list_head_ff, list_head_in;
   logic [sll_pkg::IDX_W-1:0]          free_head_ff, free_head_in;
   logic [sll_pkg::IDX_W-1:0]          cursor_ff, cursor_in;
   logic [sll_pkg::IDX_W-1:0]          prior_ff, prior_in;
   logic [sll_pkg::IDX_W-1:0]          count_ff, count_in;
   logic signed [sll_pkg::VALUE_W-1:0] res_value_ff, res_value_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic signed [sll_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [sll_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // node RAM access
   logic [sll_pkg::IDX_W-1:0]          rd_idx;
   logic [sll_pkg::ADDR_W-1:0]         rd_addr_ff;
   logic                               lnk_we;
   logic [sll_pkg::IDX_W-1:0]          lnk_widx;
   logic [sll_pkg::IDX_W-1:0]          lnk_wdata;
   logic                               val_we;
   logic [sll_pkg::IDX_W-1:0]          lnk_q;
   logic [sll_pkg::VALUE_W-1:0]        val_q;
   logic signed [sll_pkg::VALUE_W-1:0] val_rd;
   logic [sll_pkg::IDX_W-1:0]          link_rd;
   logic [sll_pkg::CAPACITY-1:0]       lvld_ff;

   sll_ram #(.WIDTH(sll_pkg::IDX_W), .DEPTH(sll_pkg::CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_widx[sll_pkg::ADDR_W-1:0]),
      .wr_data (lnk_wdata),
      .rd_addr (rd_idx[sll_pkg::ADDR_W-1:0]),
      .rd_data (lnk_q)
   );

   sll_ram #(.WIDTH(sll_pkg::VALUE_W), .DEPTH(sll_pkg::CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (node_ff[sll_pkg::ADDR_W-1:0]),
      .wr_data (val_ff),
      .rd_addr (rd_idx[sll_pkg::ADDR_W-1:0]),
      .rd_data (val_q)
   );

   // a link entry never written still holds its initial free-chain successor
   assign link_rd = lvld_ff[rd_addr_ff] ? lnk_q :
                    (sll_pkg::IDX_W'(rd_addr_ff) + sll_pkg::IDX_W'(1));
   assign val_rd  = $signed(val_q);

   assign req_ready       = (state_ff == sll_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sll_pkg::ST_IDLE;
         cstate_ff     <= sll_pkg::CUR_NONE;
         sorted_ff     <= 1'b0;
         list_head_ff  <= sll_pkg::NIL_IDX;
         free_head_ff  <= '0;
         cursor_ff     <= sll_pkg::NIL_IDX;
         prior_ff      <= sll_pkg::NIL_IDX;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         lvld_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         cstate_ff     <= cstate_in;
         list_head_ff  <= list_head_in;
         free_head_ff  <= free_head_in;
         cursor_ff     <= cursor_in;
         prior_ff      <= prior_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            sorted_ff <= csr_sorted_mode;
         end
         if (lnk_we) begin
            lvld_ff[lnk_widx[sll_pkg::ADDR_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      node_ff       <= node_in;
      cur_ff        <= cur_in;
      pred_ff       <= pred_in;
      nx_ff         <= nx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rd_addr_ff    <= rd_idx[sll_pkg::ADDR_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      cstate_in     = cstate_ff;
      val_in        = val_ff;
      node_in       = node_ff;
      cur_in        = cur_ff;
      pred_in       = pred_ff;
      nx_in         = nx_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      cursor_in     = cursor_ff;
      prior_in      = prior_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rd_idx        = '0;
      lnk_we        = 1'b0;
      lnk_widx      = node_ff;
      lnk_wdata     = nx_ff;
      val_we        = 1'b0;

      case (state_ff)
         sll_pkg::ST_IDLE: begin
            if (req_valid) begin
               val_in        = req_value;
               res_status_in = sll_pkg::STS_OK;
               res_value_in  = '0;
               case (sll_pkg::command_type'(req_command))
                  sll_pkg::CMD_INSERT: begin
                     if (free_head_ff == sll_pkg::NIL_IDX) begin
                        res_status_in = sll_pkg::STS_FULL;
                        state_in      = sll_pkg::ST_FINISH;
                     end else begin
                        rd_idx   = free_head_ff;
                        node_in  = free_head_ff;
                        state_in = sll_pkg::ST_INS_ALLOC;
                     end
                  end
                  sll_pkg::CMD_FIRST: begin
                     if (list_head_ff == sll_pkg::NIL_IDX) begin
                        res_status_in = sll_pkg::STS_END;
                        state_in      = sll_pkg::ST_FINISH;
                     end else begin
                        rd_idx   = list_head_ff;
                        cur_in   = list_head_ff;
                        state_in = sll_pkg::ST_RD_FIRST;
                     end
                  end
                  sll_pkg::CMD_NEXT: begin
                     if (cstate_ff == sll_pkg::CUR_NONE) begin
                        res_status_in = sll_pkg::STS_NOCUR;
                        state_in      = sll_pkg::ST_FINISH;
                     end else if (cursor_ff == sll_pkg::NIL_IDX) begin
                        // stepped back before the first entry
                        if (list_head_ff == sll_pkg::NIL_IDX) begin
                           res_status_in = sll_pkg::STS_END;
                           state_in      = sll_pkg::ST_FINISH;
                        end else begin
                           rd_idx   = list_head_ff;
                           cur_in   = list_head_ff;
                           state_in = sll_pkg::ST_NXT_VAL;
                        end
                     end else begin
                        rd_idx   = cursor_ff;
                        state_in = sll_pkg::ST_NXT_LINK;
                     end
                  end
                  sll_pkg::CMD_REMOVE: begin
                     if (cstate_ff != sll_pkg::CUR_ON || cursor_ff == sll_pkg::NIL_IDX) begin
                        res_status_in = sll_pkg::STS_NOCUR;
                        state_in      = sll_pkg::ST_FINISH;
                     end else begin
                        rd_idx   = cursor_ff;
                        state_in = sll_pkg::ST_RM_RD;
                     end
                  end
                  default: begin
                     state_in = sll_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         sll_pkg::ST_INS_ALLOC: begin
            free_head_in = link_rd;
            val_we       = 1'b1;
            pred_in      = sll_pkg::NIL_IDX;
            if (!sorted_ff || list_head_ff == sll_pkg::NIL_IDX) begin
               nx_in    = list_head_ff;
               state_in = sll_pkg::ST_LINK;
            end else begin
               rd_idx   = list_head_ff;
               cur_in   = list_head_ff;
               state_in = sll_pkg::ST_WALK;
            end
         end

         // one list node per cycle: data of cur_ff arrives, next read issued
         sll_pkg::ST_WALK: begin
            if (val_ff < val_rd) begin
               nx_in    = cur_ff;
               state_in = sll_pkg::ST_LINK;
            end else begin
               pred_in = cur_ff;
               if (link_rd == sll_pkg::NIL_IDX) begin
                  nx_in    = sll_pkg::NIL_IDX;
                  state_in = sll_pkg::ST_LINK;
               end else begin
                  rd_idx = link_rd;
                  cur_in = link_rd;
               end
            end
         end

         sll_pkg::ST_LINK: begin
            lnk_we    = 1'b1;
            lnk_widx  = node_ff;
            lnk_wdata = nx_ff;
            count_in  = count_ff + sll_pkg::IDX_W'(1);
            cstate_in = sll_pkg::CUR_NONE;
            if (pred_ff == sll_pkg::NIL_IDX) begin
               list_head_in = node_ff;
               state_in     = sll_pkg::ST_FINISH;
            end else begin
               state_in = sll_pkg::ST_LINK2;
            end
         end

         sll_pkg::ST_LINK2: begin
            lnk_we    = 1'b1;
            lnk_widx  = pred_ff;
            lnk_wdata = node_ff;
            state_in  = sll_pkg::ST_FINISH;
         end

         sll_pkg::ST_RD_FIRST: begin
            res_value_in = val_rd;
            prior_in     = sll_pkg::NIL_IDX;
            cursor_in    = cur_ff;
            cstate_in    = sll_pkg::CUR_ON;
            state_in     = sll_pkg::ST_FINISH;
         end

         sll_pkg::ST_NXT_LINK: begin
            if (link_rd == sll_pkg::NIL_IDX) begin
               res_status_in = sll_pkg::STS_END;
               state_in      = sll_pkg::ST_FINISH;
            end else begin
               rd_idx   = link_rd;
               cur_in   = link_rd;
               state_in = sll_pkg::ST_NXT_VAL;
            end
         end

         sll_pkg::ST_NXT_VAL: begin
            res_value_in = val_rd;
            prior_in     = cursor_ff;
            cursor_in    = cur_ff;
            cstate_in    = sll_pkg::CUR_ON;
            state_in     = sll_pkg::ST_FINISH;
         end

         // removed node goes to the front of the free chain
         sll_pkg::ST_RM_RD: begin
            res_value_in = val_rd;
            lnk_we       = 1'b1;
            lnk_widx     = cursor_ff;
            lnk_wdata    = free_head_ff;
            free_head_in = cursor_ff;
            cursor_in    = prior_ff;
            cstate_in    = sll_pkg::CUR_BACK;
            if (count_ff != '0) begin
               count_in = count_ff - sll_pkg::IDX_W'(1);
            end
            if (prior_ff == sll_pkg::NIL_IDX) begin
               list_head_in = link_rd;
               state_in     = sll_pkg::ST_FINISH;
            end else begin
               nx_in    = link_rd;
               state_in = sll_pkg::ST_RM_FIX;
            end
         end

         sll_pkg::ST_RM_FIX: begin
            lnk_we    = 1'b1;
            lnk_widx  = prior_ff;
            lnk_wdata = nx_ff;
            state_in  = sll_pkg::ST_FINISH;
         end

         sll_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = sll_pkg::count_out(count_ff);
               state_in      = sll_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sll_pkg::ST_IDLE;
         end
      endcase
   end

   `SLL_ASSERT_IMP(a_count_range, clock, reset, 1'b1,
      count_ff <= sll_pkg::NIL_IDX, "entry count above capacity")
   `SLL_ASSERT_IMP(a_full_free, clock, reset, state_ff == sll_pkg::ST_IDLE,
      (free_head_ff == sll_pkg::NIL_IDX) == (count_ff == sll_pkg::NIL_IDX),
      "free chain and count disagree")
   `SLL_ASSERT_IMP(a_empty_head, clock, reset, state_ff == sll_pkg::ST_IDLE,
      (list_head_ff == sll_pkg::NIL_IDX) == (count_ff == '0),
      "list head and count disagree")
   `SLL_ASSERT_IMP(a_cursor_on, clock, reset, cstate_ff == sll_pkg::CUR_ON,
      cursor_ff != sll_pkg::NIL_IDX, "cursor on entry but null")
   `SLL_ASSERT_IMP(a_zero_on_err, clock, reset,
      rsp_valid_ff && rsp_status_ff != sll_pkg::STS_OK,
      rsp_value_ff == '0, "nonzero value on error status")

endmodule

`default_nettype wire
